/* rtl/zrss_pkg.sv */
package zrss_pkg;

   // Fixed field widths of the stream and configuration ports.
   localparam int FIELD_BITS        = 24;
   localparam int PITCH_BITS        = 16;
   localparam int TOL_BITS          = 16;
   localparam int TIMEOUT_BITS      = 24;
   localparam int REST_BITS         = 16;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 24;
   localparam int REQ_TDATA_BITS    = 56;
   localparam int RSP_TDATA_BITS    = 56;

   // Default setpoint width inside the block.
   localparam int POSITION_BITS_DEFAULT = 24;

   // Ticks of Y stillness needed before the next sweep starts.
   localparam logic [REST_BITS-1:0] REST_TICKS = 16'd50000;

   // Register reset values.
   localparam logic [PITCH_BITS-1:0]   LINE_PITCH_RESET = 16'd1;
   localparam logic [TOL_BITS-1:0]     TOLERANCE_RESET  = 16'd16;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET    = 24'd1000;

   // Request kinds carried on req_tuser.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_START_X   = 3'd0,
      CSR_STOP_X    = 3'd1,
      CSR_START_Y   = 3'd2,
      CSR_STOP_Y    = 3'd3,
      CSR_PITCH     = 3'd4,
      CSR_TOLERANCE = 3'd5,
      CSR_TIMEOUT   = 3'd6
   } csr_index_type;

   // Status flags of one result.
   typedef struct packed {
      logic fast_approach;
      logic scan_done;
   } rsp_flags_type;

endpackage

/* rtl/zrss_csr.sv */
module zrss_csr
   import zrss_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output logic [POSITION_BITS-1:0]  start_x,
   output logic [POSITION_BITS-1:0]  stop_x,
   output logic [POSITION_BITS-1:0]  start_y,
   output logic [POSITION_BITS-1:0]  stop_y,
   output logic [PITCH_BITS-1:0]     line_pitch,
   output logic [TOL_BITS-1:0]       tolerance,
   output logic [TIMEOUT_BITS-1:0]   settle_timeout
);

   logic [POSITION_BITS-1:0] start_x_ff, start_x_in;
   logic [POSITION_BITS-1:0] stop_x_ff, stop_x_in;
   logic [POSITION_BITS-1:0] start_y_ff, start_y_in;
   logic [POSITION_BITS-1:0] stop_y_ff, stop_y_in;
   logic [PITCH_BITS-1:0]    pitch_ff, pitch_in;
   logic [TOL_BITS-1:0]      tol_ff, tol_in;
   logic [TIMEOUT_BITS-1:0]  timeout_ff, timeout_in;
   logic [POSITION_BITS-1:0] wdata_pos;

   // Positions are kept at the internal setpoint width.
   assign wdata_pos = POSITION_BITS'(csr_wdata);

   // Register write decode; indexes beyond the list are dropped.
   always_comb begin
      start_x_in = start_x_ff;
      stop_x_in  = stop_x_ff;
      start_y_in = start_y_ff;
      stop_y_in  = stop_y_ff;
      pitch_in   = pitch_ff;
      tol_in     = tol_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_X:   start_x_in = wdata_pos;
            CSR_STOP_X:    stop_x_in  = wdata_pos;
            CSR_START_Y:   start_y_in = wdata_pos;
            CSR_STOP_Y:    stop_y_in  = wdata_pos;
            CSR_PITCH:     pitch_in   = csr_wdata[PITCH_BITS-1:0];
            CSR_TOLERANCE: tol_in     = csr_wdata[TOL_BITS-1:0];
            CSR_TIMEOUT:   timeout_in = csr_wdata[TIMEOUT_BITS-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         stop_x_ff  <= '0;
         start_y_ff <= '0;
         stop_y_ff  <= '0;
         pitch_ff   <= LINE_PITCH_RESET;
         tol_ff     <= TOLERANCE_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         start_x_ff <= start_x_in;
         stop_x_ff  <= stop_x_in;
         start_y_ff <= start_y_in;
         stop_y_ff  <= stop_y_in;
         pitch_ff   <= pitch_in;
         tol_ff     <= tol_in;
         timeout_ff <= timeout_in;
      end
   end

   assign start_x        = start_x_ff;
   assign stop_x         = stop_x_ff;
   assign start_y        = start_y_ff;
   assign stop_y         = stop_y_ff;
   assign line_pitch     = pitch_ff;
   assign tolerance      = tol_ff;
   assign settle_timeout = timeout_ff;

endmodule

/* rtl/zrss_core.sv */
module zrss_core
   import zrss_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic                     op,
   input  logic [POSITION_BITS-1:0] x_position,
   input  logic [POSITION_BITS-1:0] y_position,
   input  logic                     y_moving,
   input  logic [POSITION_BITS-1:0] start_x,
   input  logic [POSITION_BITS-1:0] stop_x,
   input  logic [POSITION_BITS-1:0] start_y,
   input  logic [POSITION_BITS-1:0] stop_y,
   input  logic [PITCH_BITS-1:0]    line_pitch,
   input  logic [TOL_BITS-1:0]      tolerance,
   input  logic [TIMEOUT_BITS-1:0]  settle_timeout,
   output logic [POSITION_BITS-1:0] x_target,
   output logic [POSITION_BITS-1:0] y_target,
   output rsp_flags_type            flags
);

   localparam int CMP_BITS = ((POSITION_BITS > TOL_BITS) ? POSITION_BITS : TOL_BITS) + 1;
   localparam int SUM_BITS = ((POSITION_BITS > PITCH_BITS) ? POSITION_BITS : PITCH_BITS) + 1;

   logic [POSITION_BITS-1:0] x_target_ff, x_target_in;
   logic [POSITION_BITS-1:0] y_target_ff, y_target_in;
   logic                     sweep_ff, sweep_in;
   logic                     forward_ff, forward_in;
   logic                     seeking_ff, seeking_in;
   logic                     active_ff, active_in;
   logic                     settle_run_ff, settle_run_in;
   logic [TIMEOUT_BITS-1:0]  settle_cnt_ff, settle_cnt_in;
   logic [REST_BITS-1:0]     rest_cnt_ff, rest_cnt_in;

   logic [TIMEOUT_BITS-1:0]  settle_dec;
   logic [TIMEOUT_BITS-1:0]  settle_load;
   logic [REST_BITS-1:0]     rest_inc;
   logic [SUM_BITS-1:0]      y_sum;
   logic [POSITION_BITS-1:0] y_step;
   logic [POSITION_BITS-1:0] y_short;
   logic                     end_reached;
   logic                     x_at_target;
   logic                     y_at_target;

   // Absolute distance within the position tolerance.
   function automatic logic near(input logic [POSITION_BITS-1:0] a,
                                 input logic [POSITION_BITS-1:0] b,
                                 input logic [TOL_BITS-1:0]      tol);
      logic [POSITION_BITS-1:0] diff;
      diff = (a >= b) ? (a - b) : (b - a);
      return CMP_BITS'(diff) <= CMP_BITS'(tol);
   endfunction

   // Shared comparisons and arithmetic of one tick.
   always_comb begin
      settle_dec  = (settle_run_ff && (settle_cnt_ff != '0)) ? settle_cnt_ff - 1'b1
                                                              : settle_cnt_ff;
      settle_load = settle_run_ff ? settle_dec : settle_timeout;
      rest_inc    = (rest_cnt_ff != {REST_BITS{1'b1}}) ? rest_cnt_ff + 1'b1 : rest_cnt_ff;
      y_sum       = SUM_BITS'(y_target_ff) + SUM_BITS'(line_pitch);
      y_step      = ((y_sum >> POSITION_BITS) != '0) ? {POSITION_BITS{1'b1}}
                                                      : y_sum[POSITION_BITS-1:0];
      y_short     = stop_y - y_position;
      end_reached = near(x_target_ff, stop_x, tolerance) &&
                    ((stop_y <= y_position) ||
                     (CMP_BITS'(y_short) <= CMP_BITS'(tolerance)));
      x_at_target = near(x_position, x_target_ff, tolerance);
      y_at_target = near(y_position, y_target_ff, tolerance);
   end

   // Next state and result flags of the accepted item.
   always_comb begin
      x_target_in         = x_target_ff;
      y_target_in         = y_target_ff;
      sweep_in            = sweep_ff;
      forward_in          = forward_ff;
      seeking_in          = seeking_ff;
      active_in           = active_ff;
      settle_run_in       = settle_run_ff;
      settle_cnt_in       = settle_cnt_ff;
      rest_cnt_in         = rest_cnt_ff;
      flags.fast_approach = 1'b0;
      flags.scan_done     = 1'b0;

      if (op == OP_START) begin
         // Start command: head for the start corner at full speed.
         x_target_in         = start_x;
         y_target_in         = start_y;
         forward_in          = 1'b1;
         sweep_in            = 1'b0;
         seeking_in          = 1'b1;
         active_in           = 1'b1;
         settle_run_in       = 1'b0;
         settle_cnt_in       = '0;
         rest_cnt_in         = '0;
         flags.fast_approach = 1'b1;
      end else if (active_ff) begin
         settle_cnt_in = settle_dec;
         if (end_reached) begin
            // End of the scan: one done pulse, then idle.
            active_in       = 1'b0;
            seeking_in      = 1'b0;
            flags.scan_done = 1'b1;
         end else if (seeking_ff && !(x_at_target && y_at_target)) begin
            flags.fast_approach = 1'b1;
         end else begin
            seeking_in = 1'b0;
            if (sweep_ff) begin
               // Sweep finished: step Y by one line.
               if (x_at_target) begin
                  y_target_in = y_step;
                  sweep_in    = 1'b0;
               end
            end else if (y_at_target) begin
               // Y reached: wait for rest or the settle timeout.
               settle_run_in = 1'b1;
               settle_cnt_in = settle_load;
               if ((settle_load == '0) ||
                   (!y_moving && (rest_inc >= REST_TICKS))) begin
                  settle_run_in = 1'b0;
                  settle_cnt_in = '0;
                  rest_cnt_in   = '0;
                  x_target_in   = forward_ff ? stop_x : start_x;
                  forward_in    = !forward_ff;
                  sweep_in      = 1'b1;
               end else begin
                  rest_cnt_in = y_moving ? '0 : rest_inc;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_target_ff   <= '0;
         y_target_ff   <= '0;
         sweep_ff      <= 1'b0;
         forward_ff    <= 1'b1;
         seeking_ff    <= 1'b0;
         active_ff     <= 1'b0;
         settle_run_ff <= 1'b0;
         settle_cnt_ff <= '0;
         rest_cnt_ff   <= '0;
      end else if (step_en) begin
         x_target_ff   <= x_target_in;
         y_target_ff   <= y_target_in;
         sweep_ff      <= sweep_in;
         forward_ff    <= forward_in;
         seeking_ff    <= seeking_in;
         active_ff     <= active_in;
         settle_run_ff <= settle_run_in;
         settle_cnt_ff <= settle_cnt_in;
         rest_cnt_ff   <= rest_cnt_in;
      end
   end

   // Results show the setpoints after the step.
   assign x_target = x_target_in;
   assign y_target = y_target_in;

endmodule

/* rtl/zigzag_raster_setpoint_sequencer_unit.sv */
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser: op; tdata: x_position, y_position, y_moving
// rsp      out        rsp_tvalid/rsp_tready  tdata: x_setpoint, y_setpoint, fast_approach,
//                                                   scan_done
// csr      in         csr_we                 csr_index, csr_wdata
//
// One result per request; the result becomes valid after its request transfer has passed
// the input register and the result register.
// A request can be taken every cycle while the result register drains; the rate is set
// by the step logic between the input register and the result register.
// Reset is synchronous and active high and returns the handshake, scan state and
// configuration registers to their defaults.
// When rsp_tready is low the result register holds and the input register
// fills; req_tready then drops until the result is taken.
module zigzag_raster_setpoint_sequencer_unit
   import zrss_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tuser,   // op
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // x_position, y_position, y_moving, zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // x_setpoint, y_setpoint, fast_approach,
                                                  // scan_done, zero pad
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                     in_valid_ff, in_valid_in;
   logic                     in_op_ff;
   logic [POSITION_BITS-1:0] in_x_ff;
   logic [POSITION_BITS-1:0] in_y_ff;
   logic                     in_moving_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [FIELD_BITS-1:0]    out_x_ff;
   logic [FIELD_BITS-1:0]    out_y_ff;
   rsp_flags_type            out_flags_ff;

   logic                     advance;
   logic                     req_fire;
   logic [POSITION_BITS-1:0] start_x, stop_x, start_y, stop_y;
   logic [PITCH_BITS-1:0]    line_pitch;
   logic [TOL_BITS-1:0]      tolerance;
   logic [TIMEOUT_BITS-1:0]  settle_timeout;
   logic [POSITION_BITS-1:0] x_target, y_target;
   rsp_flags_type            flags;

   zrss_csr #(
      .POSITION_BITS (POSITION_BITS)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .start_x        (start_x),
      .stop_x         (stop_x),
      .start_y        (start_y),
      .stop_y         (stop_y),
      .line_pitch     (line_pitch),
      .tolerance      (tolerance),
      .settle_timeout (settle_timeout)
   );

   zrss_core #(
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .op             (in_op_ff),
      .x_position     (in_x_ff),
      .y_position     (in_y_ff),
      .y_moving       (in_moving_ff),
      .start_x        (start_x),
      .stop_x         (stop_x),
      .start_y        (start_y),
      .stop_y         (stop_y),
      .line_pitch     (line_pitch),
      .tolerance      (tolerance),
      .settle_timeout (settle_timeout),
      .x_target       (x_target),
      .y_target       (y_target),
      .flags          (flags)
   );

   // The held request moves on when the result register is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register, loaded on each request transfer.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff     <= req_tuser;
         in_x_ff      <= POSITION_BITS'(req_tdata[FIELD_BITS-1:0]);
         in_y_ff      <= POSITION_BITS'(req_tdata[2*FIELD_BITS-1:FIELD_BITS]);
         in_moving_ff <= req_tdata[2*FIELD_BITS];
      end
   end

   // Result register, loaded when the step is taken.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff     <= FIELD_BITS'(x_target);
         out_y_ff     <= FIELD_BITS'(y_target);
         out_flags_ff <= flags;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS-2*FIELD_BITS-2){1'b0}},
                        out_flags_ff.scan_done, out_flags_ff.fast_approach,
                        out_y_ff, out_x_ff};

endmodule

/* dv/zrss_setpoint_checker.sv */
`timescale 1ns / 100ps

// Watches the request, result and register ports of the raster sequencer,
// keeps its own copy of the scan state and compares every result transfer
// with the setpoints predicted for the oldest outstanding request.
module zrss_setpoint_checker
   import zrss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic                      req_tuser,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        mismatch_count,
   output int                        pending_count,
   output int                        checked_count,
   output int                        done_count
);

   localparam int REPORT_LIMIT = 10;
   localparam int MOVING_BIT   = 2 * FIELD_BITS;
   localparam int FAST_BIT     = 2 * FIELD_BITS;
   localparam int DONE_BIT     = 2 * FIELD_BITS + 1;

   localparam logic [FIELD_BITS-1:0] POS_MAX = '1;

   typedef struct packed {
      logic [FIELD_BITS-1:0] x_setpoint;
      logic [FIELD_BITS-1:0] y_setpoint;
      logic                  fast_approach;
      logic                  scan_done;
   } setpoint_result_type;

   // Shadow copies of the configuration registers.
   logic [FIELD_BITS-1:0]   start_x_reg, stop_x_reg, start_y_reg, stop_y_reg;
   logic [PITCH_BITS-1:0]   pitch_reg;
   logic [TOL_BITS-1:0]     tol_reg;
   logic [TIMEOUT_BITS-1:0] timeout_reg;

   // Shadow copy of the scan state.
   logic [FIELD_BITS-1:0]   x_target, y_target;
   logic                    on_x_sweep, x_forward, seeking_start, scan_active;
   logic                    settle_running;
   logic [TIMEOUT_BITS-1:0] settle_count;
   logic [REST_BITS-1:0]    rest_count;

   setpoint_result_type expected_setpoints[$];

   function automatic logic within_tol(input logic [FIELD_BITS-1:0] a,
                                       input logic [FIELD_BITS-1:0] b);
      logic [FIELD_BITS-1:0] delta;
      delta = (a > b) ? a - b : b - a;
      return delta <= tol_reg;
   endfunction

   task automatic reset_shadow();
      start_x_reg    = '0;
      stop_x_reg     = '0;
      start_y_reg    = '0;
      stop_y_reg     = '0;
      pitch_reg      = LINE_PITCH_RESET;
      tol_reg        = TOLERANCE_RESET;
      timeout_reg    = TIMEOUT_RESET;
      x_target       = '0;
      y_target       = '0;
      on_x_sweep     = 1'b0;
      x_forward      = 1'b1;
      seeking_start  = 1'b0;
      scan_active    = 1'b0;
      settle_running = 1'b0;
      settle_count   = '0;
      rest_count     = '0;
   endtask

   // One control tick or start command: update the shadow state and
   // produce the setpoints the block should report for it.
   task automatic predict_setpoints(input logic op,
                                    input logic [FIELD_BITS-1:0] xp,
                                    input logic [FIELD_BITS-1:0] yp,
                                    input logic y_moving,
                                    output setpoint_result_type res);
      logic [FIELD_BITS:0] y_next;
      logic                advance;
      int                  y_gap;
      res.fast_approach = 1'b0;
      res.scan_done     = 1'b0;
      if (op == OP_START) begin
         x_target       = start_x_reg;
         y_target       = start_y_reg;
         x_forward      = 1'b1;
         on_x_sweep     = 1'b0;
         seeking_start  = 1'b1;
         scan_active    = 1'b1;
         settle_running = 1'b0;
         settle_count   = '0;
         rest_count     = '0;
         res.fast_approach = 1'b1;
      end else if (scan_active) begin
         if (settle_running && settle_count != 0)
            settle_count = settle_count - 1'b1;
         y_gap = int'(stop_y_reg) - int'(yp);
         if (within_tol(x_target, stop_x_reg) && y_gap <= int'(tol_reg)) begin
            // End of scan wins over everything else in this tick.
            scan_active   = 1'b0;
            seeking_start = 1'b0;
            res.scan_done = 1'b1;
         end else if (seeking_start &&
                      !(within_tol(x_target, xp) && within_tol(y_target, yp))) begin
            res.fast_approach = 1'b1;
         end else begin
            // The start corner is reached; sweep logic runs in the same tick.
            seeking_start = 1'b0;
            if (on_x_sweep) begin
               if (within_tol(xp, x_target)) begin
                  y_next = {1'b0, y_target} + pitch_reg;
                  y_target = (y_next > {1'b0, POS_MAX}) ? POS_MAX : y_next[FIELD_BITS-1:0];
                  on_x_sweep = 1'b0;
               end
            end else if (within_tol(yp, y_target)) begin
               advance = 1'b1;
               if (!settle_running) begin
                  settle_count   = timeout_reg;
                  settle_running = 1'b1;
               end
               if (settle_count != 0) begin
                  if (y_moving) begin
                     rest_count = '0;
                     advance    = 1'b0;
                  end else begin
                     if (rest_count != '1)
                        rest_count = rest_count + 1'b1;
                     if (rest_count < REST_TICKS)
                        advance = 1'b0;
                  end
               end
               if (advance) begin
                  settle_running = 1'b0;
                  settle_count   = '0;
                  rest_count     = '0;
                  x_target       = x_forward ? stop_x_reg : start_x_reg;
                  x_forward      = !x_forward;
                  on_x_sweep     = 1'b1;
               end
            end
         end
      end
      res.x_setpoint = x_target;
      res.y_setpoint = y_target;
   endtask

   // Register writes, request prediction and result comparison, in that order.
   always @(posedge clock) begin : monitor
      setpoint_result_type predicted;
      setpoint_result_type observed;
      setpoint_result_type wanted;
      if (reset) begin
         reset_shadow();
         expected_setpoints.delete();
         mismatch_count = 0;
         pending_count  = 0;
         checked_count  = 0;
         done_count     = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START_X:   start_x_reg = csr_wdata[FIELD_BITS-1:0];
               CSR_STOP_X:    stop_x_reg  = csr_wdata[FIELD_BITS-1:0];
               CSR_START_Y:   start_y_reg = csr_wdata[FIELD_BITS-1:0];
               CSR_STOP_Y:    stop_y_reg  = csr_wdata[FIELD_BITS-1:0];
               CSR_PITCH:     pitch_reg   = csr_wdata[PITCH_BITS-1:0];
               CSR_TOLERANCE: tol_reg     = csr_wdata[TOL_BITS-1:0];
               CSR_TIMEOUT:   timeout_reg = csr_wdata[TIMEOUT_BITS-1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            predict_setpoints(req_tuser, req_tdata[FIELD_BITS-1:0],
                              req_tdata[2*FIELD_BITS-1:FIELD_BITS],
                              req_tdata[MOVING_BIT], predicted);
            expected_setpoints.push_back(predicted);
         end

         if (rsp_tvalid && rsp_tready) begin
            observed.x_setpoint    = rsp_tdata[FIELD_BITS-1:0];
            observed.y_setpoint    = rsp_tdata[2*FIELD_BITS-1:FIELD_BITS];
            observed.fast_approach = rsp_tdata[FAST_BIT];
            observed.scan_done     = rsp_tdata[DONE_BIT];
            checked_count++;
            if (observed.scan_done === 1'b1)
               done_count++;
            if (expected_setpoints.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display({"%0t: result transfer with nothing outstanding: ",
                            "x=%0d y=%0d fast=%0b done=%0b"},
                           $time, observed.x_setpoint, observed.y_setpoint,
                           observed.fast_approach, observed.scan_done);
               mismatch_count++;
            end else begin
               wanted = expected_setpoints.pop_front();
               if (observed.x_setpoint !== wanted.x_setpoint ||
                   observed.y_setpoint !== wanted.y_setpoint ||
                   observed.fast_approach !== wanted.fast_approach ||
                   observed.scan_done !== wanted.scan_done) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display({"%0t: mismatch: want x=%0d y=%0d fast=%0b done=%0b, ",
                               "got x=%0d y=%0d fast=%0b done=%0b"},
                              $time, wanted.x_setpoint, wanted.y_setpoint,
                              wanted.fast_approach, wanted.scan_done,
                              observed.x_setpoint, observed.y_setpoint,
                              observed.fast_approach, observed.scan_done);
                  mismatch_count++;
               end
            end
         end
         pending_count = expected_setpoints.size();
      end
   end

endmodule

/* dv/tb_zigzag_raster_setpoint_sequencer_unit.sv */
`timescale 1ns / 100ps

module tb_zigzag_raster_setpoint_sequencer_unit;
   import zrss_pkg::*;

   localparam int STALL_LIMIT      = 4000;
   localparam int HOLD_OFF_CYCLES  = 500;
   localparam int RANDOM_PHASES    = 9;
   localparam int PHASE_ITEMS      = 120;
   localparam int TAIL_ITEMS       = 150;
   localparam int DRAIN_CYCLES     = 4;
   localparam logic [FIELD_BITS-1:0] POS_MAX = '1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic                      req_tuser = OP_TICK;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int done_count;

   // Stimulus control and what the stimulus has learned from the results.
   logic                  idle_enable = 1'b1;
   logic                  hold_request = 1'b0;
   logic                  hold_served = 1'b0;
   int                    hold_left = 0;
   int                    ready_burst = 0;
   int                    quiet_cycles = 0;
   int                    items_sent = 0;
   int                    settings_count = 0;
   int                    scans_seen = 0;
   int                    scans_served = 0;
   logic [FIELD_BITS-1:0] seen_x = '0;
   logic [FIELD_BITS-1:0] seen_y = '0;
   logic [TOL_BITS-1:0]   tol_cfg = TOLERANCE_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   zigzag_raster_setpoint_sequencer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   zrss_setpoint_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .done_count     (done_count)
   );

   // The stimulus follows the reported setpoints like a stage would.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         seen_x <= rsp_tdata[FIELD_BITS-1:0];
         seen_y <= rsp_tdata[2*FIELD_BITS-1:FIELD_BITS];
         if (rsp_tdata[2*FIELD_BITS+1])
            scans_seen <= scans_seen + 1;
      end
   end

   // Receiver: random ready bursts, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         ready_burst <= 0;
         hold_left   <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1)
            rsp_tready <= 1'b1;
      end else if (hold_request && !hold_served) begin
         hold_served <= 1'b1;
         hold_left   <= HOLD_OFF_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (!idle_enable) begin
         rsp_tready  <= 1'b1;
         ready_burst <= 0;
      end else if (ready_burst > 0) begin
         ready_burst <= ready_burst - 1;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
         rsp_tready  <= 1'b0;
         ready_burst <= $urandom_range(1, 19);
      end else begin
         rsp_tready  <= 1'b1;
         ready_burst <= $urandom_range(1, 40);
      end
   end

   // Watchdog: cycles without any transfer on any port.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

   // A point within or just outside the tolerance window around a setpoint.
   function automatic logic [FIELD_BITS-1:0] near_point(input logic [FIELD_BITS-1:0] center,
                                                        input int tol);
      int magnitude;
      int value;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3)
         magnitude = 0;
      else if (pick < 9)
         magnitude = $urandom_range(0, tol);
      else
         magnitude = tol + $urandom_range(1, 3);
      if ($urandom_range(0, 1) == 0)
         value = int'(center) + magnitude;
      else
         value = int'(center) - magnitude;
      if (value < 0)
         value = 0;
      if (value > int'(POS_MAX))
         value = int'(POS_MAX);
      return value[FIELD_BITS-1:0];
   endfunction

   // One request transfer, with an optional gap in front of it.
   task automatic send_item(input logic op, input logic [FIELD_BITS-1:0] xp,
                            input logic [FIELD_BITS-1:0] yp, input logic y_moving);
      int gap;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_BITS'({y_moving, yp, xp});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_start();
      scans_served = scans_seen;
      send_item(OP_START, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                1'($urandom_range(0, 1)));
   endtask

   // A control tick: mostly tracking the setpoints, sometimes noise.
   task automatic send_tick(input int moving_pct, input int noise_pct);
      int                    pick;
      logic [FIELD_BITS-1:0] xp;
      logic [FIELD_BITS-1:0] yp;
      logic                  y_moving;
      pick = $urandom_range(0, 99);
      if (pick < noise_pct) begin
         xp = FIELD_BITS'($urandom);
         yp = FIELD_BITS'($urandom);
      end else if (pick < noise_pct + 5) begin
         xp = near_point(seen_x, int'(tol_cfg));
         yp = FIELD_BITS'($urandom);
      end else begin
         xp = near_point(seen_x, int'(tol_cfg));
         yp = near_point(seen_y, int'(tol_cfg));
      end
      y_moving = ($urandom_range(0, 99) < moving_pct);
      send_item(OP_TICK, xp, yp, y_moving);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Registers change only with the block idle and every result collected.
   task automatic apply_settings(input logic [FIELD_BITS-1:0] sx, input logic [FIELD_BITS-1:0] ex,
                                 input logic [FIELD_BITS-1:0] sy, input logic [FIELD_BITS-1:0] ey,
                                 input logic [PITCH_BITS-1:0] pitch,
                                 input logic [TOL_BITS-1:0] tol,
                                 input logic [TIMEOUT_BITS-1:0] timeout_ticks);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_START_X, sx);
      write_reg(CSR_STOP_X, ex);
      write_reg(CSR_START_Y, sy);
      write_reg(CSR_STOP_Y, ey);
      // Unused upper bits of the narrow registers carry junk.
      write_reg(CSR_PITCH, {8'($urandom_range(0, 255)), pitch});
      write_reg(CSR_TOLERANCE, {8'($urandom_range(0, 255)), tol});
      write_reg(CSR_TIMEOUT, timeout_ticks);
      csr_we  <= 1'b0;
      tol_cfg = tol;
      settings_count++;
   endtask

   // Random scan geometry, with a few fixed shapes for the extremes.
   task automatic configure_phase(input int kind);
      logic [FIELD_BITS-1:0]   sx, ex, sy, ey;
      logic [PITCH_BITS-1:0]   pitch;
      logic [TOL_BITS-1:0]     tol;
      logic [TIMEOUT_BITS-1:0] timeout_ticks;
      int                      lines;
      int                      ey_sum;
      pitch         = PITCH_BITS'($urandom_range(1, 4000));
      lines         = $urandom_range(0, 4);
      tol           = TOL_BITS'($urandom_range(0, 64));
      timeout_ticks = TIMEOUT_BITS'($urandom_range(0, 6));
      sx            = FIELD_BITS'($urandom);
      ex            = FIELD_BITS'($urandom);
      sy            = FIELD_BITS'($urandom_range(0, 1000000));
      case (kind)
         0: begin
            sx            = '0;
            ex            = POS_MAX;
            tol           = '0;
            timeout_ticks = '0;
         end
         1: begin
            sx  = POS_MAX;
            ex  = '0;
            tol = '1;
         end
         3: sy = FIELD_BITS'($urandom_range(5000000, 16000000));
         4: begin
            sy    = POS_MAX - FIELD_BITS'($urandom_range(0, 70000));
            pitch = '1;
         end
         default: ;
      endcase
      ey_sum = int'(sy) + int'(pitch) * lines;
      if (ey_sum > int'(POS_MAX))
         ey_sum = int'(POS_MAX);
      ey = ey_sum[FIELD_BITS-1:0];
      // Stop edge at or below the start edge.
      if (kind == 3)
         ey = sy - FIELD_BITS'($urandom_range(0, 100000));
      apply_settings(sx, ex, sy, ey, pitch, tol, timeout_ticks);
   endtask

   initial begin : stimulus
      int phase;
      int i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: idle ticks, then a scan that ends at once.
      send_item(OP_TICK, '0, '0, 1'b0);
      send_item(OP_TICK, POS_MAX, POS_MAX, 1'b1);
      send_item(OP_START, POS_MAX, '0, 1'b1);
      send_item(OP_TICK, '0, POS_MAX, 1'b0);
      send_item(OP_TICK, 24'd123, 24'd456, 1'b1);

      // Zero timeout with Y stepping into saturation at the top edge.
      apply_settings(24'd100, 24'd1000, POS_MAX - 24'd10, POS_MAX, '1, 16'd5, '0);
      send_item(OP_START, '0, '0, 1'b0);
      send_item(OP_TICK, '0, '0, 1'b0);
      send_item(OP_TICK, 24'd100, POS_MAX - 24'd10, 1'b1);
      send_item(OP_TICK, 24'd1000, POS_MAX - 24'd10, 1'b0);
      send_item(OP_TICK, 24'd1000, POS_MAX - 24'd3, 1'b0);
      send_item(OP_TICK, 24'd1000, POS_MAX, 1'b0);

      // Zero pitch and zero tolerance; motion clears the rest count, the
      // timer expires, and a start command restarts a running scan.
      apply_settings(24'd50, 24'd60, 24'd500, 24'd700, '0, '0, 24'd2);
      send_item(OP_START, 24'd7, 24'd9, 1'b1);
      send_item(OP_TICK, 24'd50, 24'd500, 1'b0);
      send_item(OP_TICK, 24'd50, 24'd500, 1'b1);
      send_item(OP_TICK, 24'd50, 24'd500, 1'b0);
      send_item(OP_TICK, 24'd60, 24'd500, 1'b0);
      send_item(OP_TICK, 24'd60, 24'd500, 1'b0);
      send_item(OP_TICK, 24'd60, 24'd500, 1'b1);
      send_item(OP_START, '0, POS_MAX, 1'b0);
      send_item(OP_TICK, 24'd50, 24'd500, 1'b0);

      // Random scans over several geometries.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure_phase(phase % 5);
         send_start();
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 3 && i == 20)
               hold_request = 1'b1;
            if ((scans_seen != scans_served && $urandom_range(0, 3) == 0) ||
                $urandom_range(0, 199) == 0)
               send_start();
            else
               send_tick(30, 10);
         end
      end

      // Last stretch runs without idling on either side.
      idle_enable = 1'b0;
      configure_phase(2);
      send_start();
      for (i = 0; i < TAIL_ITEMS; i++) begin
         if (scans_seen != scans_served && $urandom_range(0, 3) == 0)
            send_start();
         else
            send_tick(30, 10);
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests under %0d register settings; %0d results checked.",
               items_sent, settings_count, checked_count);
      $display("Scans completed: %0d; mismatches: %0d; results outstanding: %0d.",
               done_count, mismatch_count, pending_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/zrss_pkg.sv
rtl/zrss_csr.sv
rtl/zrss_core.sv
rtl/zigzag_raster_setpoint_sequencer_unit.sv
dv/zrss_setpoint_checker.sv
dv/tb_zigzag_raster_setpoint_sequencer_unit.sv
